@@ sv/stb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer bank package
// Shared types and constants for the timer bank core and its timer storage.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int TIMERS_DEFAULT      = 4;
  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int ID_WIDTH            = 3;
  localparam int PERIOD_WIDTH        = 32;
  localparam int UPTIME_WIDTH        = 31;

  localparam logic [UPTIME_WIDTH-1:0] UPTIME_WRAP       = 31'h7FFF_FFFF;
  localparam logic [7:0]              SCAN_DIVIDE_RESET = 8'd10;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_CHECK,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TICK,
    OP_LOAD,
    OP_CHECK
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_OP,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [ID_WIDTH-1:0]     index;
    logic [PERIOD_WIDTH-1:0] data;
  } stb_cmd_t;

endpackage

@@ sv/stb_timer_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer storage and countdown unit
// Holds the count and expiry flag of every timer and applies one command per
// cycle through a single shared decrementer.
// ----------------------------------------------------------------------------
module stb_timer_bank #(
  parameter int TIMERS      = stb_pkg::TIMERS_DEFAULT,
  parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  stb_pkg::stb_cmd_t cmd,
  output logic             expired
);
  import stb_pkg::*;

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  logic [COUNT_WIDTH-1:0] remaining [TIMERS];
  logic [TIMERS-1:0]      done_flag;

  logic [IDX_W-1:0]       idx;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] cur;
  logic                   cur_done;
  logic [COUNT_WIDTH-1:0] dec;

  assign idx      = cmd.index[IDX_W-1:0];
  assign in_range = ({{(32-ID_WIDTH){1'b0}}, cmd.index} < 32'(TIMERS));
  assign cur      = in_range ? remaining[idx] : '0;
  assign cur_done = in_range & done_flag[idx];
  assign dec      = cur - COUNT_WIDTH'(1);
  assign expired  = (cmd.op == OP_CHECK) & cur_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIMERS; i++) begin
        remaining[i] <= '0;
      end
      done_flag <= '0;
    end else if (in_range) begin
      case (cmd.op)
        OP_TICK: begin
          if (!cur_done && cur != '0) begin
            remaining[idx] <= dec;
            if (dec == '0) begin
              done_flag[idx] <= 1'b1;
            end
          end
        end
        OP_LOAD: begin
          remaining[idx] <= cmd.data[COUNT_WIDTH-1:0];
          done_flag[idx] <= 1'b0;
        end
        OP_CHECK: begin
          done_flag[idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/soft_timer_bank_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer bank core
// Bank of one-shot countdown timers with a run-time counter and scan prescaler.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and busy stays
// high until its result has been shown. A tick passes S_TICK, where one
// shared decrementer visits the timers one per cycle, then S_RESP; a start
// or check passes S_OP then S_RESP, and a read goes straight to S_RESP.
// Every transaction gives one result, shown for exactly one cycle with done
// high; the receiver cannot stall it, so it must take the result in that cycle.
module soft_timer_bank_core #(
  parameter int TIMERS      = stb_pkg::TIMERS_DEFAULT,
  parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind,
  input  logic [stb_pkg::ID_WIDTH-1:0]      timer_id,
  input  logic [stb_pkg::PERIOD_WIDTH-1:0]  period,
  output logic                              done,
  output logic                              expired,
  output logic [stb_pkg::UPTIME_WIDTH-1:0]  run_time,
  output logic                              scan_strobe
);
  import stb_pkg::*;

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMERS - 1);

  state_t                  state;
  state_t                  state_next;
  kind_t                   kind_r;
  logic [ID_WIDTH-1:0]     id_r;
  logic [PERIOD_WIDTH-1:0] period_r;
  logic [IDX_W-1:0]        tidx;
  logic [UPTIME_WIDTH-1:0] uptime;
  logic [UPTIME_WIDTH-1:0] uptime_inc;
  logic [7:0]              prescale_count;
  logic [7:0]              prescale_inc;
  logic [7:0]              scan_divide;
  logic                    res_expired;
  logic [UPTIME_WIDTH-1:0] res_run_time;
  logic                    res_strobe;
  logic                    accept;
  stb_cmd_t                cmd;
  logic                    bank_expired;

  stb_timer_bank #(
    .TIMERS      (TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .expired (bank_expired)
  );

  assign busy         = (state != S_IDLE);
  assign accept       = start & ~busy;
  assign uptime_inc   = uptime + UPTIME_WIDTH'(1);
  assign prescale_inc = prescale_count + 8'd1;

  assign expired     = res_expired;
  assign run_time    = res_run_time;
  assign scan_strobe = res_strobe;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.index  = id_r;
    cmd.data   = period_r;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_TICK:  state_next = S_TICK;
            KIND_START: state_next = S_OP;
            KIND_CHECK: state_next = S_OP;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_TICK: begin
        cmd.op    = OP_TICK;
        cmd.index = ID_WIDTH'(tidx);
        if (tidx == LAST_IDX) begin
          state_next = S_RESP;
        end
      end
      S_OP: begin
        cmd.op     = (kind_r == KIND_START) ? OP_LOAD : OP_CHECK;
        state_next = S_RESP;
      end
      S_RESP: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uptime         <= '0;
      prescale_count <= '0;
      scan_divide    <= SCAN_DIVIDE_RESET;
      tidx           <= '0;
    end else begin
      if (cfg_we) begin
        scan_divide <= cfg_data;
      end
      if (accept) begin
        tidx <= '0;
        if (kind_t'(kind) == KIND_TICK) begin
          uptime <= (uptime_inc == UPTIME_WRAP) ? '0 : uptime_inc;
          prescale_count <= (prescale_inc >= scan_divide) ? 8'd0 : prescale_inc;
        end
      end else if (state == S_TICK) begin
        tidx <= tidx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= kind_t'(kind);
      id_r         <= timer_id;
      period_r     <= period;
      res_expired  <= 1'b0;
      res_run_time <= (kind_t'(kind) == KIND_READ) ? uptime : '0;
      res_strobe   <= (kind_t'(kind) == KIND_TICK) && (prescale_inc >= scan_divide);
    end else if (state == S_OP && kind_r == KIND_CHECK) begin
      res_expired <= bank_expired;
    end
  end

endmodule
